// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CTPI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CTPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ctpi_pkg.sv =====
// Shared types, constants and the octant sine/cosine tables of the chirp injector.
package ctpi_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int PHASE_BITS       = 32;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
  localparam int OCT_BITS  = IDX_BITS - 3;
  localparam int OCT_SIZE  = SINE_TABLE_DEPTH / 8;
  localparam int TAB_BITS  = 32;

  localparam int AMP_BITS      = 16;
  localparam int RATE_BITS     = 32;
  localparam int STEP_BITS     = 32;
  localparam int CNT_BITS      = 24;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam int TONE_SHIFT = 47 - SAMPLE_BITS;
  localparam int PROD_BITS  = AMP_BITS + 1 + TAB_BITS;
  localparam int SUM_BITS   = SAMPLE_BITS + 2;

  localparam int MID_DEPTH    = 2;
  localparam int MID_PTR_BITS = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH    = 8;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);

  localparam logic signed [PROD_BITS-1:0] TONE_ROUND =
    PROD_BITS'(longint'(1) << (TONE_SHIFT - 1));
  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    SUM_BITS'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO =
    SUM_BITS'(-(longint'(1) << (SAMPLE_BITS - 1)));

  localparam longint Q30_ONE    = longint'(1) << 30;
  localparam longint TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PULSE_MODE   = 3'd0,
    REG_START_RATE   = 3'd1,
    REG_RATE_STEP    = 3'd2,
    REG_AMPLITUDE    = 3'd3,
    REG_PULSE_PERIOD = 3'd4,
    REG_PULSE_ON     = 3'd5
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [TAB_BITS-1:0]    tab_t;
  typedef tab_t qtab_t [OCT_SIZE+1];

  typedef struct packed {
    logic                        pulse_mode;
    logic [RATE_BITS-1:0]        start_rate;
    logic signed [STEP_BITS-1:0] rate_step;
    logic [AMP_BITS-1:0]         amplitude;
    logic [CNT_BITS-1:0]         pulse_period;
    logic [CNT_BITS-1:0]         pulse_on;
  } cfg_t;

  typedef struct packed {
    logic                 load;
    logic [RATE_BITS-1:0] value;
  } rate_ld_t;

  typedef struct packed {
    sample_t             re;
    sample_t             im;
    logic                add;
    logic [IDX_BITS-1:0] idx;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
    logic    tone_added;
    logic    clipped;
  } out_t;

  // One octant of sin or cos in Q2.30, truncated Horner polynomials.
  function automatic qtab_t build_octant(input logic want_cos);
    longint r;
    longint x;
    longint x2;
    longint a;
    longint s;
    longint c;
    qtab_t  tab;
    for (int j = 0; j <= OCT_SIZE; j++) begin
      r  = longint'(j) <<< (29 - OCT_BITS);
      x  = (r * TWO_PI_Q30) >>> 32;
      x2 = (x * x) >>> 30;
      a  = Q30_ONE - x2 / 42;
      a  = Q30_ONE - ((x2 * a) >>> 30) / 20;
      a  = Q30_ONE - ((x2 * a) >>> 30) / 6;
      s  = (x * a) >>> 30;
      a  = Q30_ONE - x2 / 56;
      a  = Q30_ONE - ((x2 * a) >>> 30) / 30;
      a  = Q30_ONE - ((x2 * a) >>> 30) / 12;
      c  = Q30_ONE - ((x2 * a) >>> 30) / 2;
      tab[j] = want_cos ? tab_t'(c) : tab_t'(s);
    end
    return tab;
  endfunction

  localparam qtab_t SIN_OCT = build_octant(1'b0);
  localparam qtab_t COS_OCT = build_octant(1'b1);

endpackage

// ===== rtl/ctpi_front.sv =====
// Front end: accept samples, gate the tone, advance phase, rate and pulse counter.
module ctpi_front import ctpi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  sample_t  in_sample_re,
  input  sample_t  in_sample_im,
  input  cfg_t     cfg,
  input  rate_ld_t rate_ld,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output item_t    q_item
);

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] rate_r, rate_nxt;
  logic [CNT_BITS-1:0]   pos_r, pos_nxt;
  logic [CNT_BITS:0]     pos_inc;
  logic                  gate;

  assign q_push  = in_push && !q_stat.full;
  assign gate    = !cfg.pulse_mode || (pos_r < cfg.pulse_on);
  assign pos_inc = {1'b0, pos_r} + (CNT_BITS+1)'(1);

  assign q_item.re  = in_sample_re;
  assign q_item.im  = in_sample_im;
  assign q_item.add = gate;
  assign q_item.idx = phase_r[PHASE_BITS-1 -: IDX_BITS];

  always_comb begin
    phase_nxt = phase_r;
    rate_nxt  = rate_r;
    pos_nxt   = pos_r;
    if (q_push) begin
      phase_nxt = phase_r + rate_r;
      rate_nxt  = rate_r + PHASE_BITS'(cfg.rate_step);
      // wrap at the period; a zero period behaves as one
      if (pos_inc >= {1'b0, cfg.pulse_period}) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc[CNT_BITS-1:0];
      end
    end
    if (rate_ld.load) begin
      rate_nxt = PHASE_BITS'(rate_ld.value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      rate_r  <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      rate_r  <= rate_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ===== rtl/ctpi_queue.sv =====
// Short queue between the front and back ends.
module ctpi_queue import ctpi_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t stat
);

  item_t                 mem_r [MID_DEPTH];
  logic [MID_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [MID_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [MID_PTR_BITS:0]   cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (MID_PTR_BITS+1)'(MID_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + MID_PTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + MID_PTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (MID_PTR_BITS+1)'(push) - (MID_PTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/ctpi_back.sv =====
// Back end: table lookup, octant fold, amplitude scaling, saturating add, result queue.
module ctpi_back import ctpi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [AMP_BITS-1:0] amplitude,
  input  item_t               head,
  input  q_stat_t             q_stat,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output out_t                out_head
);

  localparam int CRED_BITS = OUT_PTR_BITS + 2;

  // stage 1: raw octant table values
  logic          v1_r;
  logic [2:0]    oct1_r;
  tab_t          s1_r, c1_r;
  sample_t       re1_r, im1_r;
  logic          add1_r;
  // stage 2: folded cos/sin
  logic          v2_r;
  tab_t          cv2_r, sv2_r;
  sample_t       re2_r, im2_r;
  logic          add2_r;
  // stage 3: scaled products
  logic          v3_r;
  logic signed [PROD_BITS-1:0] pre3_r, pim3_r;
  sample_t       re3_r, im3_r;
  logic          add3_r;

  logic [2:0]          oct;
  logic [OCT_BITS-1:0] jlo;
  logic [OCT_BITS:0]   jsel;
  tab_t                sa, ca, sv, cv;
  logic signed [AMP_BITS:0] amp_s;
  logic signed [PROD_BITS-1:0] tre, tim;
  logic signed [SUM_BITS-1:0]  sum_re, sum_im;
  out_t                res;

  out_t                    omem_r [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] owr_r, ord_r;
  logic [OUT_PTR_BITS:0]   ocnt_r, ocnt_nxt;
  logic [CRED_BITS-1:0]    used;
  logic                    ord_en;

  // reserve queue space for everything in flight before taking an item
  assign used  = CRED_BITS'(ocnt_r) + CRED_BITS'(v1_r) + CRED_BITS'(v2_r) + CRED_BITS'(v3_r);
  assign q_pop = !q_stat.empty && (used < CRED_BITS'(OUT_DEPTH));

  assign oct  = head.idx[IDX_BITS-1 -: 3];
  assign jlo  = head.idx[OCT_BITS-1:0];
  assign jsel = head.idx[IDX_BITS-3] ? (OCT_BITS+1)'(OCT_SIZE) - {1'b0, jlo} : {1'b0, jlo};

  always_comb begin
    sa = oct1_r[0] ? c1_r : s1_r;
    ca = oct1_r[0] ? s1_r : c1_r;
    case (oct1_r[2:1])
      2'd0:    begin sv = sa;  cv = ca;  end
      2'd1:    begin sv = ca;  cv = -sa; end
      2'd2:    begin sv = -sa; cv = -ca; end
      default: begin sv = -ca; cv = sa;  end
    endcase
  end

  assign amp_s = $signed({1'b0, amplitude});

  always_comb begin
    tre    = (pre3_r + TONE_ROUND) >>> TONE_SHIFT;
    tim    = (pim3_r + TONE_ROUND) >>> TONE_SHIFT;
    sum_re = SUM_BITS'(re3_r) + SUM_BITS'(tre);
    sum_im = SUM_BITS'(im3_r) + SUM_BITS'(tim);
    res.tone_added = add3_r;
    res.clipped    = 1'b0;
    res.re         = re3_r;
    res.im         = im3_r;
    if (add3_r) begin
      if (sum_re > SAT_HI) begin
        res.re = SAMPLE_BITS'(SAT_HI);
        res.clipped = 1'b1;
      end else if (sum_re < SAT_LO) begin
        res.re = SAMPLE_BITS'(SAT_LO);
        res.clipped = 1'b1;
      end else begin
        res.re = SAMPLE_BITS'(sum_re);
      end
      if (sum_im > SAT_HI) begin
        res.im = SAMPLE_BITS'(SAT_HI);
        res.clipped = 1'b1;
      end else if (sum_im < SAT_LO) begin
        res.im = SAMPLE_BITS'(SAT_LO);
        res.clipped = 1'b1;
      end else begin
        res.im = SAMPLE_BITS'(sum_im);
      end
    end
  end

  always_ff @(posedge clk) begin
    oct1_r <= oct;
    s1_r   <= SIN_OCT[jsel];
    c1_r   <= COS_OCT[jsel];
    re1_r  <= head.re;
    im1_r  <= head.im;
    add1_r <= head.add;
    cv2_r  <= cv;
    sv2_r  <= sv;
    re2_r  <= re1_r;
    im2_r  <= im1_r;
    add2_r <= add1_r;
    pre3_r <= amp_s * cv2_r;
    pim3_r <= amp_s * sv2_r;
    re3_r  <= re2_r;
    im3_r  <= im2_r;
    add3_r <= add2_r;
    if (v3_r) begin
      omem_r[owr_r] <= res;
    end
  end

  assign out_empty = (ocnt_r == '0);
  assign out_head  = omem_r[ord_r];
  assign ord_en    = out_pop && !out_empty;
  assign ocnt_nxt  = ocnt_r + (OUT_PTR_BITS+1)'(v3_r) - (OUT_PTR_BITS+1)'(ord_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      v1_r   <= q_pop;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      owr_r  <= v3_r ? owr_r + OUT_PTR_BITS'(1) : owr_r;
      ord_r  <= ord_en ? ord_r + OUT_PTR_BITS'(1) : ord_r;
      ocnt_r <= ocnt_nxt;
    end
  end

endmodule

// ===== rtl/chirp_tone_pulse_injector.sv =====
// Top level: register file, front end, queue and back end of the chirp tone injector.
// Throughput: one sample per cycle while in_full is low; the back end credit check against the 8-entry
//   result queue sets how far the output side may lag before in_full rises.
// Reset: synchronous active-low; clears phase, rate, pulse counter, queues and
//   all config registers to their defaults (pulse_period 1, others 0).
`include "assert_macros.svh"

module chirp_tone_pulse_injector import ctpi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // sample input, queue style
  input  logic                     in_push,
  output logic                     in_full,
  input  sample_t                  in_sample_re,
  input  sample_t                  in_sample_im,
  // result output, queue style
  output logic                     out_empty,
  input  logic                     out_pop,
  output sample_t                  out_result_re,
  output sample_t                  out_result_im,
  output logic                     out_tone_added,
  output logic                     out_clipped,
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t     cfg_r, cfg_nxt;
  rate_ld_t rate_ld;
  logic     cfg_wr;
  q_stat_t  mid_stat;
  logic     mid_push, mid_pop;
  item_t    mid_item, mid_head;
  out_t     out_head;

  // Register writes are always taken; cfg_ready is tied high.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Decode the write; unknown indexes leave everything as is.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_PULSE_MODE:   cfg_nxt.pulse_mode   = cfg_data[0];
        REG_START_RATE:   cfg_nxt.start_rate   = RATE_BITS'(cfg_data);
        REG_RATE_STEP:    cfg_nxt.rate_step    = STEP_BITS'(cfg_data);
        REG_AMPLITUDE:    cfg_nxt.amplitude    = cfg_data[AMP_BITS-1:0];
        REG_PULSE_PERIOD: cfg_nxt.pulse_period = cfg_data[CNT_BITS-1:0];
        REG_PULSE_ON:     cfg_nxt.pulse_on     = cfg_data[CNT_BITS-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  // A start_rate write also reloads the running rate in the same edge.
  assign rate_ld.load  = cfg_wr && (cfg_reg_t'(cfg_index) == REG_START_RATE);
  assign rate_ld.value = RATE_BITS'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pulse_mode: 1'b0, start_rate: '0, rate_step: '0, amplitude: '0,
                 pulse_period: CNT_BITS'(1), pulse_on: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: take the sample, decide the gate, snapshot the table index,
  // then advance phase, rate and pulse position.
  ctpi_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_sample_re (in_sample_re),
    .in_sample_im (in_sample_im),
    .cfg          (cfg_r),
    .rate_ld      (rate_ld),
    .q_stat       (mid_stat),
    .q_push       (mid_push),
    .q_item       (mid_item)
  );

  // Hold classified items until the back end has room for them.
  ctpi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_item (mid_item),
    .pop       (mid_pop),
    .head      (mid_head),
    .stat      (mid_stat)
  );

  assign in_full = mid_stat.full;

  // Back end: lookup, fold, scale, add with saturation, queue the result.
  ctpi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .amplitude (cfg_r.amplitude),
    .head      (mid_head),
    .q_stat    (mid_stat),
    .q_pop     (mid_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_head  (out_head)
  );

  assign out_result_re  = out_head.re;
  assign out_result_im  = out_head.im;
  assign out_tone_added = out_head.tone_added;
  assign out_clipped    = out_head.clipped;

  // A sample without tone passes unchanged and can never clip.
  `CTPI_ASSERT_IMP(a_no_clip_without_tone, !out_empty && !out_tone_added, !out_clipped, "clip flagged without tone")
  // Nothing can be waiting in the first cycle out of reset.
  `CTPI_ASSERT_IMP(a_empty_after_reset, !$past(rst_n), out_empty, "result present right after reset")
  // An accepted sample is in the queue on the next edge.
  `CTPI_ASSERT_NEXT(a_push_lands, in_push && !in_full, !mid_stat.empty, "accepted sample lost")

endmodule
